>>> rtl/dss_pkg.sv
// shared types and constants of the diffusion stencil block
package dss_pkg;

   localparam int PIXEL_BITS    = 16;
   localparam int FRAC_BITS     = 16;
   localparam int COEFF_W       = 32;
   localparam int WID_W         = 11;
   localparam int HGT_W         = 13;
   localparam int COL_W         = 10;
   localparam int ROW_W         = 12;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [WID_W-1:0] RST_FRAME_WIDTH  = WID_W'(1024);
   localparam logic [HGT_W-1:0] RST_FRAME_HEIGHT = HGT_W'(1024);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEFF_A      = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_in;
      logic                  frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic [COL_W-1:0]      out_col;
      logic [ROW_W-1:0]      out_row;
      logic                  frame_last;
   } rsp_payload_type;

endpackage

>>> rtl/diffusion_stencil_step.sv
// five-point diffusion stencil over a raster pixel stream, one pass
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_data (pixel_in, frame_start)
//   rsp      out  rsp_valid/rsp_ready  rsp_data (pixel_out, out_col, out_row, frame_last)
//   csr      in   csr_wr_en            csr_index, csr_wr_data
//
// a border pixel is transferred with a line store read, then written back in ST_MUL
// an interior pixel then runs through the one-bit-per-cycle restoring divider
// the next pixel is taken while a finished result waits in the output register
// reset is synchronous and clears counters, left pixel, registers and the output slot
// line stores hold undefined data after reset and get no clearing pass
module diffusion_stencil_step #(
   parameter int MAX_WIDTH = dss_pkg::DEF_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dss_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dss_pkg::rsp_payload_type           rsp_data,
   input  logic                               csr_wr_en,
   input  logic [dss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int PB     = dss_pkg::PIXEL_BITS;
   localparam int CNT_W  = $clog2(MAX_WIDTH);
   localparam int WCMP_W = (CNT_W + 1 > dss_pkg::WID_W) ? CNT_W + 1 : dss_pkg::WID_W;
   localparam int HW     = dss_pkg::HGT_W;
   localparam int RW     = dss_pkg::ROW_W;
   localparam int SUM_W  = PB + 2;
   localparam int PROD_W = dss_pkg::COEFF_W + SUM_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = dss_pkg::COEFF_W + 3;
   localparam int QCNT_W = $clog2(PB);

   // line stores
   logic [PB-1:0] prev_mem  [MAX_WIDTH];
   logic [PB-1:0] prev2_mem [MAX_WIDTH];

   dss_pkg::state_type state_ff, state_in;

   logic [dss_pkg::COEFF_W-1:0] coeff_ff;
   logic [dss_pkg::WID_W-1:0]   fwidth_ff;
   logic [HW-1:0]               fheight_ff;

   logic [CNT_W-1:0] col_ff;
   logic [RW-1:0]    row_ff;
   logic [PB-1:0]    left_ff;

   logic [CNT_W-1:0] cur_col_ff;
   logic [RW-1:0]    cur_row_ff;
   logic [PB-1:0]    pix_ff;
   logic [PB-1:0]    rd_prev_c_ff;
   logic [PB-1:0]    rd_prev_e_ff;
   logic [PB-1:0]    rd_prev2_ff;

   logic [PB-1:0]         centre_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [NUM_W-1:0]      rem_ff;
   logic [NUM_W-1:0]      dsh_ff;
   logic [PB-1:0]         quo_ff;
   logic [QCNT_W-1:0]     cnt_ff;
   logic [dss_pkg::COL_W-1:0] ocol_ff;
   logic [RW-1:0]         orow_ff;
   logic                  olast_ff;

   logic                     rsp_valid_ff;
   dss_pkg::rsp_payload_type rsp_data_ff;

   logic             accept;
   logic             load;
   logic [CNT_W-1:0] c_now;
   logic [RW-1:0]    r_now;
   logic [CNT_W-1:0] addr_east;
   logic [WCMP_W-1:0] eff_w;
   logic [HW-1:0]    eff_h;
   logic [WCMP_W-1:0] c_ext;
   logic [HW-1:0]    r_ext;
   logic             interior;
   logic             last_px;
   logic [SUM_W-1:0] sum;
   logic [DEN_W-1:0] den;
   logic [NUM_W:0]   diff;
   logic             fits;
   logic             slot_free;
   logic [CNT_W:0]   col_inc;
   logic [HW-1:0]    row_inc;
   logic [CNT_W-1:0] col_next;
   logic [RW-1:0]    row_next;

   // pixel position and effective geometry
   always_comb begin
      c_now     = req_data.frame_start ? '0 : col_ff;
      r_now     = req_data.frame_start ? '0 : row_ff;
      addr_east = (c_now == CNT_W'(MAX_WIDTH - 1)) ? '0 : c_now + 1'b1;

      if (WCMP_W'(fwidth_ff) < WCMP_W'(3)) begin
         eff_w = WCMP_W'(3);
      end else if (WCMP_W'(fwidth_ff) > WCMP_W'(MAX_WIDTH)) begin
         eff_w = WCMP_W'(MAX_WIDTH);
      end else begin
         eff_w = WCMP_W'(fwidth_ff);
      end
      if (fheight_ff < HW'(3)) begin
         eff_h = HW'(3);
      end else if (fheight_ff > HW'(dss_pkg::MAX_HEIGHT)) begin
         eff_h = HW'(dss_pkg::MAX_HEIGHT);
      end else begin
         eff_h = fheight_ff;
      end

      c_ext    = WCMP_W'(cur_col_ff);
      r_ext    = HW'(cur_row_ff);
      interior = (r_ext >= HW'(2)) && (r_ext + HW'(1) <= eff_h)
               && (c_ext >= WCMP_W'(1)) && (c_ext + WCMP_W'(2) <= eff_w);
      last_px  = (c_ext + WCMP_W'(2) == eff_w) && (r_ext + HW'(1) == eff_h);

      sum = SUM_W'(rd_prev2_ff) + SUM_W'(pix_ff) + SUM_W'(left_ff) + SUM_W'(rd_prev_e_ff);
      den = DEN_W'({coeff_ff, 2'b00}) + (DEN_W'(1) << dss_pkg::FRAC_BITS);

      diff = {1'b0, rem_ff} - {1'b0, dsh_ff};
      fits = !diff[NUM_W];

      col_inc = (CNT_W + 1)'(cur_col_ff) + 1'b1;
      row_inc = HW'(cur_row_ff) + HW'(1);
      if (WCMP_W'(col_inc) >= eff_w) begin
         col_next = '0;
         row_next = (row_inc >= eff_h) ? '0 : row_inc[RW-1:0];
      end else begin
         col_next = col_inc[CNT_W-1:0];
         row_next = cur_row_ff;
      end

      slot_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dss_pkg::ST_IDLE: begin
            if (accept) state_in = dss_pkg::ST_MUL;
         end
         dss_pkg::ST_MUL: begin
            state_in = interior ? dss_pkg::ST_ADD : dss_pkg::ST_IDLE;
         end
         dss_pkg::ST_ADD: begin
            state_in = dss_pkg::ST_DIV;
         end
         dss_pkg::ST_DIV: begin
            if (cnt_ff == '0) state_in = dss_pkg::ST_FINISH;
         end
         dss_pkg::ST_FINISH: begin
            if (slot_free) state_in = dss_pkg::ST_IDLE;
         end
         default: begin
            state_in = dss_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = (state_ff == dss_pkg::ST_IDLE);
      load      = (state_ff == dss_pkg::ST_FINISH) && slot_free;
      accept    = req_valid && req_ready;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dss_pkg::ST_IDLE;
         coeff_ff     <= '0;
         fwidth_ff    <= dss_pkg::RST_FRAME_WIDTH;
         fheight_ff   <= dss_pkg::RST_FRAME_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               dss_pkg::CSR_COEFF_A:      coeff_ff   <= csr_wr_data;
               dss_pkg::CSR_FRAME_WIDTH:  fwidth_ff  <= csr_wr_data[dss_pkg::WID_W-1:0];
               dss_pkg::CSR_FRAME_HEIGHT: fheight_ff <= csr_wr_data[HW-1:0];
               default: ;
            endcase
         end
         if (state_ff == dss_pkg::ST_MUL) begin
            col_ff  <= col_next;
            row_ff  <= row_next;
            left_ff <= rd_prev_c_ff;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // line store read and write-back
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_prev_c_ff <= prev_mem[c_now];
         rd_prev_e_ff <= prev_mem[addr_east];
         rd_prev2_ff  <= prev2_mem[c_now];
      end
      if (state_ff == dss_pkg::ST_MUL) begin
         prev_mem[cur_col_ff]  <= pix_ff;
         prev2_mem[cur_col_ff] <= rd_prev_c_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff     <= req_data.pixel_in;
         cur_col_ff <= c_now;
         cur_row_ff <= r_now;
      end
      case (state_ff)
         dss_pkg::ST_MUL: begin
            prod_ff   <= PROD_W'(coeff_ff) * PROD_W'(sum);
            centre_ff <= rd_prev_c_ff;
            ocol_ff   <= dss_pkg::COL_W'(cur_col_ff);
            orow_ff   <= cur_row_ff - 1'b1;
            olast_ff  <= last_px;
         end
         dss_pkg::ST_ADD: begin
            rem_ff <= NUM_W'({centre_ff, {dss_pkg::FRAC_BITS{1'b0}}}) + NUM_W'(prod_ff);
            dsh_ff <= NUM_W'(den) << (PB - 1);
            cnt_ff <= QCNT_W'(PB - 1);
         end
         dss_pkg::ST_DIV: begin
            if (fits) rem_ff <= diff[NUM_W-1:0];
            quo_ff <= {quo_ff[PB-2:0], fits};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
      if (load) begin
         rsp_data_ff.pixel_out  <= quo_ff;
         rsp_data_ff.out_col    <= ocol_ff;
         rsp_data_ff.out_row    <= orow_ff;
         rsp_data_ff.frame_last <= olast_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_writes_back: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == dss_pkg::ST_MUL)
      else $error("transfer not followed by line store write-back");

   a_border_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dss_pkg::ST_MUL && !interior) |=> state_ff == dss_pkg::ST_IDLE)
      else $error("border pixel entered the divider");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dss_pkg::ST_DIV && cnt_ff == '0) |=> state_ff == dss_pkg::ST_FINISH)
      else $error("divider did not finish after last step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == dss_pkg::ST_FINISH |-> rem_ff < NUM_W'(den))
      else $error("quotient overflow in divider");

endmodule

>>> verif/diffusion_stencil_checker.sv
// scoreboard for the diffusion stencil block: predicts each diffused pixel and compares results
module diffusion_stencil_checker #(
   parameter int MAX_WIDTH = dss_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  dss_pkg::req_payload_type        req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  dss_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_wr_en,
   input  logic [dss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                              errors,
   output int                              pending
);

   logic [dss_pkg::PIXEL_BITS-1:0] line_prev  [MAX_WIDTH];
   logic [dss_pkg::PIXEL_BITS-1:0] line_prev2 [MAX_WIDTH];
   logic [dss_pkg::PIXEL_BITS-1:0] left_value;
   int unsigned                    col_pos;
   int unsigned                    row_pos;
   logic [dss_pkg::COEFF_W-1:0]    coeff;
   logic [dss_pkg::WID_W-1:0]      width_reg;
   logic [dss_pkg::HGT_W-1:0]      height_reg;
   dss_pkg::rsp_payload_type       diffused_q[$];

   task automatic predict_pixel(input dss_pkg::req_payload_type item);
      int unsigned                    w;
      int unsigned                    h;
      int unsigned                    c;
      int unsigned                    r;
      logic [dss_pkg::PIXEL_BITS-1:0] centre;
      logic [17:0]                    sum;
      logic [63:0]                    num;
      logic [63:0]                    den;
      logic [63:0]                    quo;
      dss_pkg::rsp_payload_type       res;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 3) ? 3
        : (height_reg > dss_pkg::MAX_HEIGHT) ? dss_pkg::MAX_HEIGHT : height_reg;
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      centre = line_prev[c];
      if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2) begin
         sum = 18'(line_prev2[c]) + 18'(item.pixel_in) + 18'(left_value)
             + 18'(line_prev[c + 1]);
         // (c*2^16 + a*sum) / (2^16 + 4a), truncated
         num = (64'(centre) << dss_pkg::FRAC_BITS) + 64'(coeff) * 64'(sum);
         den = (64'd1 << dss_pkg::FRAC_BITS) + (64'(coeff) << 2);
         quo = num / den;
         res.pixel_out  = (quo > 64'((1 << dss_pkg::PIXEL_BITS) - 1)) ? '1
                        : quo[dss_pkg::PIXEL_BITS-1:0];
         res.out_col    = dss_pkg::COL_W'(c);
         res.out_row    = dss_pkg::ROW_W'(r - 1);
         res.frame_last = (c == w - 2) && (r == h - 1);
         diffused_q.push_back(res);
      end
      line_prev2[c] = centre;
      line_prev[c]  = item.pixel_in;
      left_value    = centre;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   always @(posedge clock) begin
      dss_pkg::rsp_payload_type exp_res;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
         end
         left_value = '0;
         col_pos    = 0;
         row_pos    = 0;
         coeff      = '0;
         width_reg  = dss_pkg::RST_FRAME_WIDTH;
         height_reg = dss_pkg::RST_FRAME_HEIGHT;
         errors     = 0;
         diffused_q.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               dss_pkg::CSR_COEFF_A:      coeff = csr_wr_data[dss_pkg::COEFF_W-1:0];
               dss_pkg::CSR_FRAME_WIDTH:  width_reg = csr_wr_data[dss_pkg::WID_W-1:0];
               dss_pkg::CSR_FRAME_HEIGHT: height_reg = csr_wr_data[dss_pkg::HGT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_pixel(req_data);
         if (rsp_valid && rsp_ready) begin
            if (diffused_q.size() == 0) begin
               $error("result with nothing expected: col %0d row %0d",
                      rsp_data.out_col, rsp_data.out_row);
               errors++;
            end else begin
               exp_res = diffused_q.pop_front();
               if (rsp_data.pixel_out !== exp_res.pixel_out) begin
                  $error("pixel_out: expected %0d, got %0d", exp_res.pixel_out,
                         rsp_data.pixel_out);
                  errors++;
               end
               if (rsp_data.out_col !== exp_res.out_col) begin
                  $error("out_col: expected %0d, got %0d", exp_res.out_col, rsp_data.out_col);
                  errors++;
               end
               if (rsp_data.out_row !== exp_res.out_row) begin
                  $error("out_row: expected %0d, got %0d", exp_res.out_row, rsp_data.out_row);
                  errors++;
               end
               if (rsp_data.frame_last !== exp_res.frame_last) begin
                  $error("frame_last: expected %0d, got %0d", exp_res.frame_last,
                         rsp_data.frame_last);
                  errors++;
               end
            end
         end
      end
      pending = diffused_q.size();
   end

endmodule

>>> verif/diffusion_stencil_step_test.sv
// testbench top for the diffusion stencil block: stimulus, flow control and verdict
module diffusion_stencil_step_test;

   localparam int RANDOM_ITEMS  = 950;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int WIDE_CUT      = 160;
   localparam int TALL_CUT      = 300;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   dss_pkg::req_payload_type        req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   dss_pkg::rsp_payload_type        rsp_data;
   logic                            csr_wr_en   = 1'b0;
   logic [dss_pkg::CSR_INDEX_W-1:0] csr_index   = dss_pkg::CSR_COEFF_A;
   logic [dss_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;
   int                              errors;
   int                              pending;
   int                              sent        = 0;
   int                              idle_cycles = 0;
   int                              hold_asks   = 0;
   bit                              offering    = 1'b0;
   bit                              send_calm   = 1'b0;
   bit                              recv_calm   = 1'b0;
   int unsigned                     cur_w       = dss_pkg::DEF_MAX_WIDTH;
   int unsigned                     cur_h       = 1024;

   diffusion_stencil_step DUT (.*);

   diffusion_stencil_checker stencil_check (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, plus a long hold whenever one is asked for
   initial begin
      int gap;
      int served;
      served = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 12);
         if (served != hold_asks) begin
            served = hold_asks;
            gap    = gap + LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic logic [dss_pkg::PIXEL_BITS-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return dss_pkg::PIXEL_BITS'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [dss_pkg::PIXEL_BITS-1:0] pix, input logic fs);
      int gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0 && offering) begin
         req_valid <= 1'b0;
         offering   = 1'b0;
      end
      repeat (gap) @(negedge clock);
      req_valid <= 1'b1;
      offering   = 1'b1;
      req_data  <= '{pixel_in: pix, frame_start: fs};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic wait_results();
      if (offering) begin
         req_valid <= 1'b0;
         offering   = 1'b0;
      end
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input dss_pkg::csr_index_type idx,
                            input logic [dss_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [dss_pkg::COEFF_W-1:0] a,
                            input logic [dss_pkg::WID_W-1:0] wreg,
                            input logic [dss_pkg::HGT_W-1:0] hreg);
      write_reg(dss_pkg::CSR_COEFF_A, dss_pkg::CSR_DATA_W'(a));
      write_reg(dss_pkg::CSR_FRAME_WIDTH, dss_pkg::CSR_DATA_W'(wreg));
      write_reg(dss_pkg::CSR_FRAME_HEIGHT, dss_pkg::CSR_DATA_W'(hreg));
      cur_w = clamp_dim(wreg, 3, dss_pkg::DEF_MAX_WIDTH);
      cur_h = clamp_dim(hreg, 3, dss_pkg::MAX_HEIGHT);
   endtask

   task automatic send_frame(input int unsigned w, input int unsigned h, input bit fs_first,
                             input int unsigned cut, input bit noisy);
      int unsigned n;
      n = w * h;
      if (cut != 0 && cut < n) n = cut;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 149) == 0) wait_results();
         send_pixel(pick_pixel(),
                    (i == 0 && fs_first) || (noisy && $urandom_range(0, 299) == 0));
      end
   endtask

   initial begin
      int unsigned                 n_frames;
      int unsigned                 cut;
      int unsigned                 old_w;
      int                          phase;
      bit                          cont;
      logic [dss_pkg::COEFF_W-1:0] a;
      logic [dss_pkg::WID_W-1:0]   wreg;
      logic [dss_pkg::HGT_W-1:0]   hreg;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // clamped 3x3 frames, full coefficient, dark and bright centres, counter wrap
      configure('1, dss_pkg::WID_W'(1), dss_pkg::HGT_W'(2));
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? '0 : '1, i == 0);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? '1 : '0, 1'b0);
      settle();
      configure('0, dss_pkg::WID_W'(0), dss_pkg::HGT_W'(0));
      for (int i = 0; i < 9; i++) begin
         send_pixel((i == 4) ? '1 : dss_pkg::PIXEL_BITS'(i * 7283), i == 0);
      end

      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 4))
            0:       a = '0;
            1:       a = '1;
            2:       a = $urandom;
            3:       a = dss_pkg::COEFF_W'(1 << dss_pkg::FRAC_BITS);
            default: a = $urandom_range(0, 32'h0004_0000);
         endcase
         if ($urandom_range(0, 7) == 0) wreg = dss_pkg::WID_W'($urandom_range(0, 2));
         else wreg = dss_pkg::WID_W'($urandom_range(3, ($urandom_range(0, 5) == 0) ? 40 : 10));
         if ($urandom_range(0, 7) == 0) hreg = dss_pkg::HGT_W'($urandom_range(0, 2));
         else hreg = dss_pkg::HGT_W'($urandom_range(3, ($urandom_range(0, 5) == 0) ? 20 : 8));
         old_w = cur_w;
         configure(a, wreg, hreg);
         // only a narrower or equal row may carry on mid-frame
         cont = (cur_w <= old_w) && ($urandom_range(0, 2) == 0);
         if (phase % 6 == 2) hold_asks++;
         n_frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < n_frames; f++) begin
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : 0;
            send_frame(cur_w, cur_h, (f == 0) ? !cont : bit'($urandom_range(0, 1)), cut, 1'b1);
         end
         phase++;
      end

      // widest and tallest geometry, leading part of each frame
      settle();
      configure($urandom, '1, dss_pkg::HGT_W'(3));
      hold_asks++;
      send_frame(cur_w, cur_h, 1'b1, WIDE_CUT, 1'b0);
      settle();
      configure($urandom_range(0, 32'h0002_0000), dss_pkg::WID_W'(3), '1);
      send_frame(cur_w, cur_h, 1'b1, TALL_CUT, 1'b0);

      settle();
      if (errors == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> diffusion_stencil_step.f
rtl/dss_pkg.sv
rtl/diffusion_stencil_step.sv
verif/diffusion_stencil_checker.sv
verif/diffusion_stencil_step_test.sv
